### rtl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// Depends on nothing; every other file in rtl imports it.
package itoa_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

	// Job queue between the front and back ends.
	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

	// floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x.
	localparam logic [32:0] RECIP10       = 33'h0CCCCCCCD;
	localparam int unsigned RECIP10_SHIFT = 35;

	typedef logic [DIGIT_W-1:0] digit_t;

	// One classified number waiting for conversion.
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} itoa_job_t;

endpackage

### rtl/itoa_num_if.sv
// Input channel: one signed 32-bit integer per word.
// Depends on itoa_pkg.
interface itoa_num_if;
	import itoa_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### rtl/itoa_char_if.sv
// Output channel: one ASCII character and its end-of-text flag per word.
// Depends on itoa_pkg.
interface itoa_char_if;
	import itoa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

### rtl/itoa_front.sv
// Front end: takes numbers, splits them into sign and magnitude, and queues them.
// Depends on itoa_pkg and itoa_num_if.
module itoa_front (
	input  logic                clk,
	input  logic                arst_n,
	itoa_num_if.sink            number,
	output logic                job_valid,
	input  logic                job_ready,
	output itoa_pkg::itoa_job_t job
);
	import itoa_pkg::*;

	itoa_job_t          fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               pop;
	itoa_job_t          cls;

	// The magnitude of the most negative value still fits in 32 unsigned bits.
	always_comb begin
		cls.neg = number.value[VALUE_W-1];
		cls.mag = cls.neg ? (~number.value + 1'b1) : number.value;
	end

	assign number.ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push         = number.valid && number.ready;
	assign job_valid    = (cnt_q != '0);
	assign pop          = job_valid && job_ready;
	assign job          = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/itoa_back.sv
// Back end: peels off decimal digits one per cycle, then sends the text out
// most significant first through a registered output stage.
// Depends on itoa_pkg and itoa_char_if.
module itoa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  itoa_pkg::itoa_job_t job,
	itoa_char_if.source         text
);
	import itoa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic                 sign_pend_q;
	logic [DIG_IDX_W-1:0] cnt_q;
	logic [DIG_IDX_W-1:0] idx_q;
	digit_t               digs_q [MAX_DIGITS];
	logic                 ovalid_q;
	logic [CHAR_W-1:0]    ochar_q;
	logic                 olast_q;

	logic [64:0]          prod;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   quot10;
	logic [VALUE_W-1:0]   diff;
	digit_t               rem;
	logic                 div_done;
	logic                 load;

	// Divide by ten with a reciprocal multiply; the remainder follows by shift-add.
	assign prod     = {33'd0, mag_q} * {32'd0, RECIP10};
	assign quot     = VALUE_W'(prod[63:RECIP10_SHIFT]);
	assign quot10   = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
	assign diff     = mag_q - quot10;
	assign rem      = diff[DIGIT_W-1:0];
	assign div_done = (quot == '0) || (cnt_q == DIG_IDX_W'(MAX_DIGITS - 1));

	assign job_ready = (state_q == ST_IDLE);
	assign load      = (state_q == ST_EMIT) && (!ovalid_q || text.ready);

	assign text.valid     = ovalid_q;
	assign text.character = ochar_q;
	assign text.last      = olast_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			digs_q[cnt_q] <= rem;
		end
		if (load) begin
			if (sign_pend_q) begin
				ochar_q <= CHAR_MINUS;
				olast_q <= 1'b0;
			end else begin
				ochar_q <= CHAR_ZERO + {4'd0, digs_q[idx_q]};
				olast_q <= (idx_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						mag_q   <= job.mag;
						neg_q   <= job.neg;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					mag_q <= quot;
					cnt_q <= cnt_q + 1'b1;
					if (div_done) begin
						idx_q       <= cnt_q;
						sign_pend_q <= neg_q;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < DIG_IDX_W'(MAX_DIGITS))
		else $error("digit count ran past the widest number");

	a_idx_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q < cnt_q)
		else $error("emit index points past the collected digits");

	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		sign_pend_q |-> neg_q && state_q == ST_EMIT)
		else $error("minus sign pending for a non-negative number");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && !sign_pend_q && idx_q == '0 |=> state_q == ST_IDLE && olast_q)
		else $error("final digit did not close the run");
`endif

endmodule

### rtl/signed_int_to_decimal_ascii_top.sv
// Channel  Dir  Word contents
// number   in   value: signed 32-bit integer
// text     out  character: 8-bit ASCII code, last: end of the number's text
//
// In the back end a number passes through the idle state, then a divide-by-ten
// loop that yields one digit per cycle, then an output stage that sends its
// text one character per cycle while the receiver is ready. A two-entry queue
// lets new numbers arrive while one is converting.
// Reset is asynchronous and clears all control state. A stalled output holds
// its word and pauses conversion; the input stalls only when the queue is full.
// Depends on itoa_pkg, itoa_num_if, itoa_char_if, itoa_front and itoa_back.
module signed_int_to_decimal_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	itoa_num_if.sink    number,
	itoa_char_if.source text
);
	import itoa_pkg::*;

	logic      job_valid;
	logic      job_ready;
	itoa_job_t job;

	itoa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (number),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	itoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.text      (text)
	);

endmodule

### sim/signed_int_to_decimal_ascii_top_tb.sv
// Self-checking testbench for signed_int_to_decimal_ascii_top: random and edge-case integers
// are converted, and every character word is checked against a predicted decimal string.
// Depends on itoa_pkg, itoa_num_if, itoa_char_if and the RTL below the top level.
module signed_int_to_decimal_ascii_top_tb;
	import itoa_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned STALL_CYCLES = 300;

	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_word_t;

	logic clk;
	logic arst_n;

	itoa_num_if  num_ch ();
	itoa_char_if txt_ch ();

	signed_int_to_decimal_ascii_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.number (num_ch),
		.text   (txt_ch)
	);

	text_word_t  pending_chars[$];
	int unsigned err_count;
	int unsigned numbers_sent;
	int unsigned chars_checked;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned stall_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d characters still expected",
					cycle_count, pending_chars.size());
				$display("** signed_int_to_decimal_ascii_top: FAILED **");
				$finish;
			end
		end
	end

	// Builds the expected text of one number: optional minus, then digits, most
	// significant first. The magnitude is taken in unsigned arithmetic so that the
	// most negative value comes out right.
	function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] mag;
		digit_t             digs[MAX_DIGITS];
		int unsigned        count;
		text_word_t         w;
		raw = value;
		mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
		count = 0;
		do begin
			digs[count] = digit_t'(mag % 10);
			mag = mag / 10;
			count++;
		end while (mag != 0 && count < MAX_DIGITS);
		if (raw[VALUE_W-1]) begin
			w.character = CHAR_MINUS;
			w.last = 1'b0;
			pending_chars.push_back(w);
		end
		for (int k = count; k > 0; k--) begin
			w.character = CHAR_ZERO + digs[k-1];
			w.last = (k == 1);
			pending_chars.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
		input logic [CHAR_W-1:0] want);
		$display("MISMATCH cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
		err_count++;
	endtask

	// Offers one number and returns once it has been taken. Valid stays high on
	// return so that back-to-back words need no gap.
	task automatic send_number(input logic signed [VALUE_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			num_ch.valid <= 1'b0;
			num_ch.value <= $urandom;
			@(posedge clk);
		end
		num_ch.valid <= 1'b1;
		num_ch.value <= value;
		do @(posedge clk); while (!num_ch.ready);
		predict_decimal_text(value);
		numbers_sent++;
	endtask

	task automatic wait_drained();
		num_ch.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] random_number();
		int unsigned        d;
		logic [VALUE_W-1:0] mag;
		d = $urandom_range(1, 9);
		case ($urandom_range(3))
			0: return $urandom;
			1: mag = 10**d - $urandom_range(1);
			default: mag = $urandom_range(10**d - 1);
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// Character checker and receiver. Ready is redrawn every cycle unless a long
	// hold-off has been requested.
	initial begin
		text_word_t  want;
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && txt_ch.valid && txt_ch.ready) begin
				if (pending_chars.size() == 0) begin
					report_mismatch("character with none expected", txt_ch.character, '0);
				end else begin
					want = pending_chars.pop_front();
					if (txt_ch.character !== want.character)
						report_mismatch("character", txt_ch.character, want.character);
					if (txt_ch.last !== want.last)
						report_mismatch("last flag", CHAR_W'(txt_ch.last),
							CHAR_W'(want.last));
					chars_checked++;
				end
			end
			if (stall_request != 0) begin
				stall_left = stall_request;
				stall_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				txt_ch.ready <= 1'b0;
			end else begin
				txt_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic test_edge_values();
		logic signed [VALUE_W-1:0] vals[$];
		vals = '{0, 1, -1, 7, -5, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
			999999999, 1000000000, -1000000000, 1234567890, -987654321,
			2147483646, 2147483647, -2147483647, 32'sh80000000};
		foreach (vals[i]) send_number(vals[i]);
		wait_drained();
	endtask

	task automatic test_random_numbers(input int unsigned count);
		repeat (count) send_number(random_number());
		wait_drained();
	endtask

	// The receiver stops for a long stretch while numbers keep coming, so the
	// job queue fills and the input has to stall.
	task automatic test_output_backpressure();
		stall_request = STALL_CYCLES;
		repeat (12) send_number(random_number());
		wait_drained();
	endtask

	initial begin
		err_count = 0;
		numbers_sent = 0;
		chars_checked = 0;
		stall_request = 0;
		src_idle_pct = 20;
		snk_idle_pct = 81;
		arst_n <= 1'b0;
		num_ch.valid <= 1'b0;
		num_ch.value <= '0;
		txt_ch.ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_random_numbers(80);
		src_idle_pct = 81;
		snk_idle_pct = 20;
		test_random_numbers(80);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_numbers(35);
		test_output_backpressure();

		if (pending_chars.size() != 0)
			report_mismatch("characters never received", CHAR_W'(pending_chars.size()), '0);
		$display("Converted %0d numbers, checked %0d characters in %0d cycles.",
			numbers_sent, chars_checked, cycle_count);
		$display("Covered edge values, all lengths, both stall patterns and a long output hold.");
		if (err_count == 0) begin
			$display("** signed_int_to_decimal_ascii_top: PASSED **");
		end else begin
			$display("%0d mismatches", err_count);
			$display("** signed_int_to_decimal_ascii_top: FAILED **");
		end
		$finish;
	end

endmodule
